[rtl/smpa_pkg.sv]
`timescale 1ns / 1ps

package smpa_pkg;

    localparam int COLUMNS     = 64;
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COL_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic               restart;
        logic               last;
        logic               empty;
    } item_t;

endpackage

[rtl/smpa_front.sv]
`timescale 1ns / 1ps

module smpa_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [31:0]         s_sample_value,
    input  logic [5:0]                 s_column_index,
    input  logic [15:0]                s_row_offset,
    input  logic                       s_last_row,
    input  logic                       s_empty_segment,
    output logic                       f_valid,
    input  logic                       f_ready,
    output smpa_pkg::item_t            f_item
);
    import smpa_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    always_comb begin
        item_next.value   = VALUE_W'(s_sample_value);
        item_next.col     = COL_W'(s_column_index);
        item_next.row     = POS_W'(s_row_offset);
        item_next.restart = (s_row_offset == 16'd0);
        item_next.last    = s_last_row;
        item_next.empty   = s_empty_segment;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

[rtl/smpa_queue.sv]
`timescale 1ns / 1ps

module smpa_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_valid,
    output logic                       wr_ready,
    input  smpa_pkg::item_t            wr_item,
    output logic                       rd_valid,
    input  logic                       rd_pop,
    output smpa_pkg::item_t            rd_item
);
    import smpa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slots[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[rtl/smpa_back.sv]
`timescale 1ns / 1ps

module smpa_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  smpa_pkg::item_t            q_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [5:0]                 m_result_column,
    output logic signed [31:0]         m_max_value,
    output logic [15:0]                m_max_position
);
    import smpa_pkg::*;

    logic [VALUE_W-1:0] store_max [COLUMNS];
    logic [POS_W-1:0]   store_pos [COLUMNS];

    logic               b_valid_reg;
    item_t              b_item_reg;
    logic [VALUE_W-1:0] rd_max_reg;
    logic [POS_W-1:0]   rd_pos_reg;

    logic               lw_valid_reg;
    logic [COL_W-1:0]   lw_col_reg;
    logic [VALUE_W-1:0] lw_max_reg;
    logic [POS_W-1:0]   lw_pos_reg;

    logic               m_valid_reg;
    logic [COL_W-1:0]   m_col_reg;
    logic [VALUE_W-1:0] m_max_reg;
    logic [POS_W-1:0]   m_pos_reg;

    logic               out_free;
    logic               b_emit;
    logic               b_advance;
    logic               b_write;
    logic               fwd;
    logic [VALUE_W-1:0] cur_max;
    logic [POS_W-1:0]   cur_pos;
    logic [VALUE_W-1:0] new_max;
    logic [POS_W-1:0]   new_pos;

    assign out_free  = !m_valid_reg || m_ready;
    assign b_emit    = b_item_reg.empty || b_item_reg.last;
    assign b_advance = b_valid_reg && (!b_emit || out_free);
    assign b_write   = b_advance && !b_item_reg.empty;
    assign q_pop     = q_valid && (!b_valid_reg || b_advance);

    // forward the write that landed on the same edge as this item's read
    assign fwd = lw_valid_reg && (lw_col_reg == b_item_reg.col);

    always_comb begin
        if (b_item_reg.restart) begin
            cur_max = MOST_NEG;
            cur_pos = '0;
        end else if (fwd) begin
            cur_max = lw_max_reg;
            cur_pos = lw_pos_reg;
        end else begin
            cur_max = rd_max_reg;
            cur_pos = rd_pos_reg;
        end
        if ($signed(b_item_reg.value) > $signed(cur_max)) begin
            new_max = b_item_reg.value;
            new_pos = b_item_reg.row;
        end else begin
            new_max = cur_max;
            new_pos = cur_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_max_reg <= store_max[q_item.col];
            rd_pos_reg <= store_pos[q_item.col];
        end
        if (b_write) begin
            store_max[b_item_reg.col] <= new_max;
            store_pos[b_item_reg.col] <= new_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (!b_valid_reg || b_advance) begin
                b_valid_reg <= q_valid;
            end
            if (b_write) begin
                lw_valid_reg <= 1'b1;
            end
            if (out_free) begin
                m_valid_reg <= b_advance && b_emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_item_reg <= q_item;
        end
        if (b_write) begin
            lw_col_reg <= b_item_reg.col;
            lw_max_reg <= new_max;
            lw_pos_reg <= new_pos;
        end
        if (out_free && b_advance && b_emit) begin
            m_col_reg <= b_item_reg.col;
            if (b_item_reg.empty) begin
                m_max_reg <= MOST_NEG;
                m_pos_reg <= '0;
            end else begin
                m_max_reg <= new_max;
                m_pos_reg <= new_pos;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_column = 6'(m_col_reg);
    assign m_max_value     = 32'(m_max_reg);
    assign m_max_position  = 16'(m_pos_reg);

endmodule

[rtl/segment_max_pool_argmax.sv]
`timescale 1ns / 1ps

// Segment max pooling with argmax over 64 feature columns. Each item carries one element:
// a signed Q16.16 value, its column, its row offset within the segment and flags for the
// column's last row and for an empty segment. Row offset zero restarts the column; a
// strictly greater value replaces the column's maximum and its position, so ties keep the
// first row. The last row of a column emits one item with the column, its maximum and the
// row offset of that maximum; an empty segment emits the most negative value at position
// zero and leaves the store alone. A column must see row zero before any other row after
// reset. The block takes one item per cycle while the output side is not stalled: an input
// register and a four-entry queue feed a back end whose per-column store is read into a
// register as each item enters it and written back with forwarding, and an output register
// lets input continue while a result waits.
module segment_max_pool_argmax (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_sample_value,
    input  logic [5:0]          s_column_index,
    input  logic [15:0]         s_row_offset,
    input  logic                s_last_row,
    input  logic                s_empty_segment,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [5:0]          m_result_column,
    output logic signed [31:0]  m_max_value,
    output logic [15:0]         m_max_position
);
    import smpa_pkg::*;

    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    smpa_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_value  (s_sample_value),
        .s_column_index  (s_column_index),
        .s_row_offset    (s_row_offset),
        .s_last_row      (s_last_row),
        .s_empty_segment (s_empty_segment),
        .f_valid         (f_valid),
        .f_ready         (f_ready),
        .f_item          (f_item)
    );

    smpa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    smpa_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_item          (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_column (m_result_column),
        .m_max_value     (m_max_value),
        .m_max_position  (m_max_position)
    );

endmodule
